[rtl/bddn_pkg.sv]
// ----------------------------------------------------------------------------
// bddn_pkg - shared types and constants for the bounded date day number unit
// Year limits, action codes, sequencer states and calendar helper functions.
// ----------------------------------------------------------------------------
package bddn_pkg;

  localparam logic [11:0] YEAR_MIN     = 12'd1900;
  localparam logic [11:0] YEAR_MAX     = 12'd2099;
  localparam logic [11:0] YEAR_DEFAULT = 12'd2000;
  localparam logic [16:0] DAYNUM_MAX   = 17'd73049;
  localparam logic [16:0] DAYS_YEAR    = 17'd365;
  localparam logic [3:0]  MONTH_LAST   = 4'd12;

  localparam logic [1:0] ACT_SET    = 2'd0;
  localparam logic [1:0] ACT_LOAD   = 2'd1;
  localparam logic [1:0] ACT_DAYNUM = 2'd2;
  localparam logic [1:0] ACT_READ   = 2'd3;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_LOADY = 6'b000010,
    ST_LOADM = 6'b000100,
    ST_CNTY  = 6'b001000,
    ST_CNTM  = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

  typedef struct packed {
    logic        sub;
    logic [16:0] operand;
  } alu_ctl_t;

  typedef struct packed {
    logic [16:0] value;
    logic        le;
  } alu_res_t;

  // valid for 1900..2099: only 1900 is a non-leap multiple of four
  function automatic logic is_leap(logic [11:0] y);
    return (y[1:0] == 2'd0) && (y != YEAR_MIN);
  endfunction

  function automatic logic [16:0] year_len(logic [11:0] y);
    return DAYS_YEAR + {16'd0, is_leap(y)};
  endfunction

  function automatic logic [4:0] month_len(logic [11:0] y, logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd2:                      len = is_leap(y) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

[rtl/bounded_date_day_number_unit.sv]
// ----------------------------------------------------------------------------
// bounded_date_day_number_unit - Gregorian date register, 1900..2099
// Holds one date and reports it with its day number after every word.
// ----------------------------------------------------------------------------
// usage:
//   in channel: one word per action (tuser) with year, month, day and day
//   number in tdata; in_tready is high only while the unit is idle.
//   out channel: one word per input word with the stored date and its day
//   number (1900-01-01 is day 1).
// sequence: the action is applied first, then for a day number load one
//   step per whole year and per whole month walked, then one step per
//   year before the stored year and per month up to the stored month, the
//   last of which adds the day; both load walks and the year count end with
//   one extra compare step. non day number actions skip the load walks.
//   all steps go through one shared 17 bit add/subtract unit.
// throughput: one word at a time; the next word is taken after the result
//   leaves the output register.
// reset: date becomes 2000-01-01, unit idle, no result pending.
// stall: the result is held in the output register until out_tready.
// ----------------------------------------------------------------------------
module bounded_date_day_number_unit import bddn_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // in_year[15:0], in_month[23:16], in_day[31:24],
                                  // in_day_number[48:32], zero pad
  input  logic [1:0]  in_tuser,   // action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // out_year[11:0], out_month[15:12], out_day[20:16],
                                  // out_day_number[37:21], zero pad
);

  state_t      state_r, state_nxt;
  logic [11:0] cur_year_r, cur_year_nxt;
  logic [3:0]  cur_month_r, cur_month_nxt;
  logic [4:0]  cur_day_r, cur_day_nxt;
  logic [16:0] acc_r, acc_nxt;
  logic [11:0] yi_r, yi_nxt;
  logic [3:0]  mi_r, mi_nxt;

  logic [15:0] in_year;
  logic [7:0]  in_month;
  logic [7:0]  in_day;
  logic [16:0] in_day_number;

  logic        year_ok;
  logic        month_ok;
  logic [11:0] chk_year;
  logic [3:0]  chk_month;
  logic [11:0] set_year;
  logic [3:0]  set_month;
  logic [4:0]  set_len;
  logic [4:0]  load_len;

  alu_ctl_t    alu_ctl;
  alu_res_t    alu_res;

  assign in_year       = in_tdata[15:0];
  assign in_month      = in_tdata[23:16];
  assign in_day        = in_tdata[31:24];
  assign in_day_number = in_tdata[48:32];

  assign year_ok   = (in_year >= {4'd0, YEAR_MIN}) && (in_year <= {4'd0, YEAR_MAX});
  assign month_ok  = (in_month >= 8'd1) && (in_month <= {4'd0, MONTH_LAST});
  assign chk_year  = year_ok ? in_year[11:0] : YEAR_DEFAULT;
  assign chk_month = month_ok ? in_month[3:0] : 4'd1;
  assign set_year  = (in_year == 16'd0) ? cur_year_r : chk_year;
  assign set_month = (in_month == 8'd0) ? cur_month_r : chk_month;
  assign set_len   = month_len(set_year, set_month);
  assign load_len  = month_len(chk_year, chk_month);

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_OUT);
  assign out_tdata  = {2'd0, acc_r, cur_day_r, cur_month_r, cur_year_r};

  always_comb begin
    case (state_r)
      ST_LOADY: alu_ctl = '{sub: 1'b1, operand: year_len(yi_r)};
      ST_LOADM: alu_ctl = '{sub: 1'b1, operand: {12'd0, month_len(yi_r, mi_r)}};
      ST_CNTY:  alu_ctl = '{sub: 1'b0, operand: year_len(yi_r)};
      ST_CNTM: begin
        if (mi_r < cur_month_r) begin
          alu_ctl = '{sub: 1'b0, operand: {12'd0, month_len(cur_year_r, mi_r)}};
        end else begin
          alu_ctl = '{sub: 1'b0, operand: {12'd0, cur_day_r}};
        end
      end
      default:  alu_ctl = '{sub: 1'b0, operand: 17'd0};
    endcase
  end

  bddn_alu u_alu (
    .acc (acc_r),
    .ctl (alu_ctl),
    .res (alu_res)
  );

  always_comb begin
    state_nxt     = state_r;
    cur_year_nxt  = cur_year_r;
    cur_month_nxt = cur_month_r;
    cur_day_nxt   = cur_day_r;
    acc_nxt       = acc_r;
    yi_nxt        = yi_r;
    mi_nxt        = mi_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          acc_nxt   = 17'd0;
          yi_nxt    = YEAR_MIN;
          mi_nxt    = 4'd1;
          state_nxt = ST_CNTY;
          case (in_tuser)
            ACT_SET: begin
              cur_year_nxt  = set_year;
              cur_month_nxt = set_month;
              if (in_day != 8'd0) begin
                cur_day_nxt = (in_day > {3'd0, set_len}) ? 5'd1 : in_day[4:0];
              end
            end
            ACT_LOAD: begin
              cur_year_nxt  = chk_year;
              cur_month_nxt = chk_month;
              cur_day_nxt   = (in_day == 8'd0 || in_day > {3'd0, load_len}) ?
                              5'd1 : in_day[4:0];
            end
            ACT_DAYNUM: begin
              if (in_day_number <= 17'd1) begin
                cur_year_nxt  = YEAR_MIN;
                cur_month_nxt = 4'd1;
                cur_day_nxt   = 5'd1;
              end else if (in_day_number >= DAYNUM_MAX) begin
                cur_year_nxt  = YEAR_MAX;
                cur_month_nxt = MONTH_LAST;
                cur_day_nxt   = 5'd31;
              end else begin
                acc_nxt   = in_day_number;
                state_nxt = ST_LOADY;
              end
            end
            ACT_READ: begin
            end
            default: begin
            end
          endcase
        end
      end
      ST_LOADY: begin
        if (alu_res.le) begin
          state_nxt = ST_LOADM;
        end else begin
          acc_nxt = alu_res.value;
          yi_nxt  = yi_r + 12'd1;
        end
      end
      ST_LOADM: begin
        if (alu_res.le || mi_r >= MONTH_LAST) begin
          cur_year_nxt  = yi_r;
          cur_month_nxt = mi_r;
          cur_day_nxt   = acc_r[4:0];
          acc_nxt       = 17'd0;
          yi_nxt        = YEAR_MIN;
          mi_nxt        = 4'd1;
          state_nxt     = ST_CNTY;
        end else begin
          acc_nxt = alu_res.value;
          mi_nxt  = mi_r + 4'd1;
        end
      end
      ST_CNTY: begin
        if (yi_r < cur_year_r) begin
          acc_nxt = alu_res.value;
          yi_nxt  = yi_r + 12'd1;
        end else begin
          mi_nxt    = 4'd1;
          state_nxt = ST_CNTM;
        end
      end
      ST_CNTM: begin
        acc_nxt = alu_res.value;
        if (mi_r < cur_month_r) begin
          mi_nxt = mi_r + 4'd1;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cur_year_r  <= YEAR_DEFAULT;
      cur_month_r <= 4'd1;
      cur_day_r   <= 5'd1;
    end else begin
      state_r     <= state_nxt;
      cur_year_r  <= cur_year_nxt;
      cur_month_r <= cur_month_nxt;
      cur_day_r   <= cur_day_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    yi_r  <= yi_nxt;
    mi_r  <= mi_nxt;
  end

endmodule

[rtl/bddn_alu.sv]
// ----------------------------------------------------------------------------
// bddn_alu - shared add/subtract unit
// Adds or subtracts one operand from the accumulator; in subtract mode flags acc <= operand.
// ----------------------------------------------------------------------------
module bddn_alu import bddn_pkg::*; (
  input  logic [16:0] acc,
  input  alu_ctl_t    ctl,
  output alu_res_t    res
);

  logic [16:0] b;
  logic [17:0] sum;

  assign b   = ctl.sub ? ~ctl.operand : ctl.operand;
  assign sum = {1'b0, acc} + {1'b0, b} + {17'd0, ctl.sub};

  // in subtract mode carry out means acc >= operand
  assign res.value = sum[16:0];
  assign res.le    = !sum[17] || (sum[16:0] == 17'd0);

endmodule

[rtl/bddn_checker.sv]
// ----------------------------------------------------------------------------
// bddn_checker - port level checks for the bounded date day number unit
// Watches the stream ports for range and sequencing errors.
// ----------------------------------------------------------------------------
module bddn_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> in_tready && !out_tvalid)
    else $error("unit not idle after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while a result is pending");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[11:0] >= 12'd1900 && out_tdata[11:0] <= 12'd2099 &&
                   out_tdata[15:12] >= 4'd1 && out_tdata[15:12] <= 4'd12 &&
                   out_tdata[20:16] != 5'd0)
    else $error("stored date out of range");

  a_daynum_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[37:21] != 17'd0)
    else $error("day number zero");

endmodule

bind bounded_date_day_number_unit bddn_checker u_bddn_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
